// File: rtl/hue_match_pixel_classifier_defines.svh
// Assertion macros for the hue match pixel classifier checker.
// No dependencies.
`ifndef HUE_MATCH_PIXEL_CLASSIFIER_DEFINES_SVH
`define HUE_MATCH_PIXEL_CLASSIFIER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HMPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define HMPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/hmpc_pkg.sv
// Types and constants shared by the hue match pixel classifier.
// No dependencies.
package hmpc_pkg;
	localparam logic [31:0] MARK_COLOUR = 32'hff039dfd;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
	localparam logic [14:0] FULL_TURN = 15'd23040;
	localparam logic [11:0] SIXTY_DEG = 12'd3840;
	localparam logic signed [15:0] BLACK_HUE = -16'sd64;
	localparam logic CFG_TARGET_HUE = 1'b0;
	localparam logic CFG_MATCH_THRESHOLD = 1'b1;
	localparam int DIV_STEPS = 15;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_pixel;
		logic        matched;
		logic signed [15:0] pixel_hue;
	} out_item_t;

	// front to back: numerator and divisor, or a fixed hue
	typedef struct packed {
		logic [14:0] numer;
		logic [7:0]  den;
		logic        fixed;
		logic signed [15:0] fixed_hue;
	} job_t;
endpackage

// File: rtl/hmpc_front.sv
// Front part: accepts pixels, finds max/min and forms the hue numerator.
// Depends on hmpc_pkg.
module hmpc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  hmpc_pkg::in_item_t in_item,
	output logic in_ready,
	output logic job_valid,
	output hmpc_pkg::job_t job,
	input  logic job_ready
);
	import hmpc_pkg::*;
	logic [7:0] r, g, b, mx, mn, d;
	logic [15:0] num_w;
	job_t job_w;
	logic valid_q;
	job_t job_q;

	assign r = in_item.pixel_red;
	assign g = in_item.pixel_green;
	assign b = in_item.pixel_blue;

	always_comb begin
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		// numerator in sixty-degree units scaled later; product < 23040*d
		if (r == mx) begin
			if (g >= b) num_w = {8'd0, g - b};
			else num_w = 16'd6 * {8'd0, d} - {8'd0, b - g};
		end else if (g == mx) begin
			num_w = 16'd2 * {8'd0, d} + {8'd0, b} - {8'd0, r};
		end else begin
			num_w = 16'd4 * {8'd0, d} + {8'd0, r} - {8'd0, g};
		end
		job_w.numer = num_w[14:0];
		job_w.den = d;
		job_w.fixed = (mx == 8'd0) || (d == 8'd0);
		job_w.fixed_hue = (mx == 8'd0) ? BLACK_HUE : 16'sd0;
	end

	assign in_ready = !valid_q || job_ready;
	assign job_valid = valid_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) job_q <= job_w;
	end
endmodule

// File: rtl/hmpc_queue.sv
// Short queue between front and back parts.
// Depends on hmpc_pkg.
module hmpc_queue #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  hmpc_pkg::job_t wr_data,
	output logic wr_ready,
	output logic rd_valid,
	output hmpc_pkg::job_t rd_data,
	input  logic rd_ready
);
	import hmpc_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// File: rtl/hmpc_back.sv
// Back part: pipelined divide, distance, match and grey level, output register.
// Depends on hmpc_pkg.
module hmpc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  hmpc_pkg::job_t job,
	output logic job_ready,
	input  logic [14:0] target_hue,
	input  logic [14:0] match_threshold,
	output logic out_valid,
	output hmpc_pkg::out_item_t out_item,
	input  logic out_ready
);
	import hmpc_pkg::*;
	// stage 0: scale numerator by 3840
	localparam int NW = 23;
	logic v_s1;
	logic [NW-1:0] n_s1;
	logic [7:0] d_s1;
	logic fx_s1;
	logic signed [15:0] fh_s1;
	// divider pipeline: restoring, one quotient bit per stage
	logic [DIV_STEPS-1:0] v_d;
	logic [NW-1:0] rem_d [DIV_STEPS+1];
	logic [14:0] quo_d [DIV_STEPS+1];
	logic [7:0] den_d [DIV_STEPS+1];
	logic fx_d [DIV_STEPS+1];
	logic signed [15:0] fh_d [DIV_STEPS+1];
	// distance stage
	logic v_s2;
	logic signed [15:0] h_s2;
	logic [15:0] dist_s2;
	// grey level stage
	logic v_s3;
	logic signed [15:0] h_s3;
	logic hit_s3;
	logic [7:0] lvl_s3;
	logic adv;
	logic signed [16:0] diff;
	logic signed [15:0] h_w;
	logic [32:0] recip;

	// whole pipe stalls together when the output register is held
	assign adv = !out_valid || out_ready;
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_d <= '0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= job_valid;
			// v_d[k] marks the data in rem_d[k+1]
			v_d <= {v_d[DIV_STEPS-2:0], v_s1};
			v_s2 <= v_d[DIV_STEPS-1];
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	assign rem_d[0] = n_s1;
	assign quo_d[0] = '0;
	assign den_d[0] = d_s1;
	assign fx_d[0] = fx_s1;
	assign fh_d[0] = fh_s1;

	genvar i;
	generate
		for (i = 0; i < DIV_STEPS; i++) begin : g_div
			localparam int SH = DIV_STEPS - 1 - i;
			logic [NW-1:0] rem_q;
			logic [14:0] quo_q;
			logic [7:0] den_q;
			logic fx_q;
			logic signed [15:0] fh_q;
			logic [NW+SH-1:0] sub_w;
			logic ge_w;
			always_comb begin
				sub_w = {{SH{1'b0}}, den_d[i], {(NW-8){1'b0}}} >> (NW - 8 - SH);
				ge_w = {{SH{1'b0}}, rem_d[i]} >= sub_w;
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q <= ge_w ? NW'({{SH{1'b0}}, rem_d[i]} - sub_w) : rem_d[i];
					quo_q <= quo_d[i] | (ge_w ? 15'(1 << SH) : 15'd0);
					den_q <= den_d[i];
					fx_q <= fx_d[i];
					fh_q <= fh_d[i];
				end
			end
			assign rem_d[i+1] = rem_q;
			assign quo_d[i+1] = quo_q;
			assign den_d[i+1] = den_q;
			assign fx_d[i+1] = fx_q;
			assign fh_d[i+1] = fh_q;
		end
	endgenerate

	always_comb begin
		h_w = fx_d[DIV_STEPS] ? fh_d[DIV_STEPS] : $signed({1'b0, quo_d[DIV_STEPS]});
		diff = $signed({2'b00, target_hue}) - {h_w[15], h_w};
	end

	// floor(dist/90) for dist < 32832: reciprocal 2^23/90 rounded up
	assign recip = {17'd0, dist_s2} * 33'd93207;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= NW'(job.numer) * NW'(SIXTY_DEG);
			d_s1 <= job.den;
			fx_s1 <= job.fixed;
			fh_s1 <= job.fixed_hue;
			h_s2 <= h_w;
			dist_s2 <= diff[16] ? 16'(-diff) : diff[15:0];
			h_s3 <= h_s2;
			hit_s3 <= dist_s2 < {1'b0, match_threshold};
			lvl_s3 <= recip[30:23];
			out_item.pixel_hue <= h_s3;
			out_item.matched <= hit_s3;
			out_item.out_pixel <= hit_s3 ? MARK_COLOUR : {ALPHA_OPAQUE, lvl_s3, lvl_s3, lvl_s3};
		end
	end
endmodule

// File: rtl/hue_match_pixel_classifier.sv
// Top level of the hue match pixel classifier: registers, front, queue, back.
// Depends on hmpc_pkg, hmpc_front, hmpc_queue, hmpc_back.
// One pixel per clock sustained while results are popped; a pixel passes the
// front register, the queue and the 15-stage restoring divider in the back part.
// A small queue decouples front and back; results wait in an output register.
module hue_match_pixel_classifier #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  hmpc_pkg::in_item_t in_item,
	output logic full,
	output logic empty,
	output hmpc_pkg::out_item_t out_item,
	input  logic pop,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [14:0] cfg_data
);
	import hmpc_pkg::*;
	logic [14:0] target_q, thresh_q;
	logic in_ready, f_valid, f_ready, b_valid, b_ready, out_valid;
	job_t f_job, b_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			thresh_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET_HUE: target_q <= cfg_data;
				CFG_MATCH_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full = !in_ready;
	assign empty = !out_valid;

	hmpc_front u_front (.clk, .arst_n, .in_valid(push), .in_item, .in_ready,
		.job_valid(f_valid), .job(f_job), .job_ready(f_ready));
	hmpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (.clk, .arst_n, .wr_valid(f_valid),
		.wr_data(f_job), .wr_ready(f_ready), .rd_valid(b_valid), .rd_data(b_job),
		.rd_ready(b_ready));
	hmpc_back u_back (.clk, .arst_n, .job_valid(b_valid), .job(b_job),
		.job_ready(b_ready), .target_hue(target_q), .match_threshold(thresh_q),
		.out_valid, .out_item, .out_ready(pop));
endmodule

// File: rtl/hmpc_checker.sv
// Port-level checker for the hue match pixel classifier, bound to the top.
// Depends on hmpc_pkg and hue_match_pixel_classifier_defines.svh.
`include "hue_match_pixel_classifier_defines.svh"
module hmpc_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input hmpc_pkg::out_item_t out_item
);
	import hmpc_pkg::*;
	`HMPC_ASSERT_IMP(a_mark, clk, arst_n, !empty && out_item.matched,
		out_item.out_pixel == MARK_COLOUR)
	`HMPC_ASSERT_IMP(a_alpha, clk, arst_n, !empty, out_item.out_pixel[31:24] == ALPHA_OPAQUE)
	`HMPC_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_item))
	`HMPC_ASSERT_IMP(a_hue, clk, arst_n, !empty, out_item.pixel_hue >= BLACK_HUE)
endmodule

bind hue_match_pixel_classifier hmpc_checker u_checker (.clk, .arst_n, .empty,
	.pop, .out_item);

// File: tb/tb_hue_match_pixel_classifier.sv
// Testbench for hue_match_pixel_classifier: drives RGB pixels under both
// configuration registers and checks every result beat against a hue predictor.
// Depends on hmpc_pkg and the hue_match_pixel_classifier RTL.
module tb_hue_match_pixel_classifier;
	import hmpc_pkg::*;

	localparam int DRAIN_CYCLES = 30;

	logic clk;
	logic arst_n;
	logic push;
	in_item_t in_item;
	logic full;
	logic empty;
	out_item_t out_item;
	logic pop;
	logic cfg_we;
	logic cfg_index;
	logic [14:0] cfg_data;

	out_item_t expected_px[$];
	int unsigned target_reg;
	int unsigned thresh_reg;
	int errors;
	bit steady;

	hue_match_pixel_classifier u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(in_item), .full(full),
		.empty(empty), .out_item(out_item), .pop(pop), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic int calc_hue(int unsigned r, int unsigned g, int unsigned b);
		int unsigned mx, mn, d, numer;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		if (mx == 0) return -64;
		d = mx - mn;
		if (d == 0) return 0;
		if (r == mx) begin
			if (g >= b) numer = 3840 * (g - b);
			else numer = 23040 * d - 3840 * (b - g);
		end else if (g == mx) begin
			numer = 3840 * (2 * d + b - r);
		end else begin
			numer = 3840 * (4 * d + r - g);
		end
		return int'(numer / d);
	endfunction

	function automatic out_item_t classify(in_item_t px);
		out_item_t res;
		int h, hue_dist;
		logic [7:0] lvl;
		h = calc_hue(px.pixel_red, px.pixel_green, px.pixel_blue);
		hue_dist = int'(target_reg) >= h ? int'(target_reg) - h : h - int'(target_reg);
		res.matched = hue_dist < int'(thresh_reg);
		lvl = 8'((hue_dist / 90) & 255);
		res.out_pixel = res.matched ? MARK_COLOUR : {ALPHA_OPAQUE, lvl, lvl, lvl};
		res.pixel_hue = 16'(h);
		return res;
	endfunction

	// result side: random pop, compare each beat with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_px.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = expected_px.pop_front();
					if (out_item.out_pixel !== want.out_pixel) begin
						$error("out_pixel exp %h got %h", want.out_pixel, out_item.out_pixel);
						errors++;
					end
					if (out_item.matched !== want.matched) begin
						$error("matched exp %b got %b", want.matched, out_item.matched);
						errors++;
					end
					if (out_item.pixel_hue !== want.pixel_hue) begin
						$error("pixel_hue exp %0d got %0d", want.pixel_hue, out_item.pixel_hue);
						errors++;
					end
				end
			end
			pop <= steady || ($urandom_range(99) >= 28);
		end
	end

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_item_t px;
		px = '{pixel_red: r, pixel_green: g, pixel_blue: b};
		while (!steady && $urandom_range(99) < 28) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_item <= px;
		do @(posedge clk); while (full);
		expected_px.push_back(classify(px));
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 15'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TARGET_HUE) target_reg = val & 32'h7fff;
		else thresh_reg = val & 32'h7fff;
	endtask

	task automatic send_random_pixel();
		logic [7:0] r, g, b, v;
		r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
		v = 8'($urandom);
		case ($urandom_range(9))
			0: begin r = v; g = v; b = v; end
			1: begin r = v; g = v; end
			2: begin g = v; b = v; end
			3: begin r = v; b = v; end
			4: begin r = 8'hff; end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	task automatic test_special_pixels();
		write_reg(CFG_TARGET_HUE, 0);
		write_reg(CFG_MATCH_THRESHOLD, 100);
		send_pixel(8'h00, 8'h00, 8'h00); // black
		send_pixel(8'h80, 8'h80, 8'h80); // pure grey
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h01, 8'h01, 8'h01);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'hff, 8'h00, 8'h01); // red max, hue just below full turn
		send_pixel(8'hff, 8'hff, 8'h00); // red/green tie
		send_pixel(8'h00, 8'hff, 8'hff); // green/blue tie
		send_pixel(8'hff, 8'h00, 8'hff); // red/blue tie
		send_pixel(8'h01, 8'h00, 8'h00);
		send_pixel(8'hfe, 8'h01, 8'hff);
		send_pixel(8'h55, 8'haa, 8'h12);
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_TARGET_HUE, 23040);
		write_reg(CFG_MATCH_THRESHOLD, 0);
		send_pixel(8'h00, 8'h00, 8'h00); // largest distance, grey level wraps
		send_pixel(8'hff, 8'h00, 8'h01);
		write_reg(CFG_TARGET_HUE, 32767); // beyond full turn
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h10, 8'h20, 8'h30);
		write_reg(CFG_MATCH_THRESHOLD, 32767);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		write_reg(CFG_TARGET_HUE, 0);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_random_phases();
		int unsigned tgt[7] = '{0, 23040, 32767, 7680, 0, 15360, 0};
		int unsigned thr[7] = '{0, 32767, 1000, 2000, 64, 4000, 0};
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(CFG_TARGET_HUE, ph >= 4 ? $urandom_range(23040) : tgt[ph]);
			write_reg(CFG_MATCH_THRESHOLD, ph == 6 ? $urandom_range(32767) : thr[ph]);
			for (int i = 0; i < 250; i++) begin
				steady = (ph == 3) && (i >= 50) && (i < 200);
				if (ph == 5 && i == 125) drain(); // sender holds off until all results are in
				send_random_pixel();
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET_HUE;
		cfg_data = '0;
		errors = 0;
		steady = 1'b0;
		target_reg = 0;
		thresh_reg = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_pixels();
		test_config_extremes();
		test_random_phases();
		drain();
		if (errors == 0 && expected_px.size() == 0) begin
			$display("tb_hue_match_pixel_classifier passed");
		end else begin
			$display("tb_hue_match_pixel_classifier failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb_hue_match_pixel_classifier failed");
		$finish;
	end
endmodule

// File: hue_match_pixel_classifier.f
+incdir+rtl
rtl/hmpc_pkg.sv
rtl/hmpc_front.sv
rtl/hmpc_queue.sv
rtl/hmpc_back.sv
rtl/hue_match_pixel_classifier.sv
rtl/hmpc_checker.sv
tb/tb_hue_match_pixel_classifier.sv
